@@ sv/hemisphere_direction_sampler_macros.svh @@
// Assertion macros used by the hemisphere direction sampler checker.
`ifndef HEMISPHERE_DIRECTION_SAMPLER_MACROS_SVH
`define HEMISPHERE_DIRECTION_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define HDS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hemisphere_direction_sampler check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define HDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hemisphere_direction_sampler check failed");

`endif

@@ sv/hds_pkg.sv @@
// Package with item types and fixed constants of the hemisphere direction sampler.
`timescale 1ns / 1ps
package hds_pkg;

	typedef struct packed {
		logic        [15:0] rand_height;
		logic        [15:0] rand_angle;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} hds_in_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic               degenerate_normal;
	} hds_out_t;

	// Radicand widths of the two square roots (local radius and tangent length).
	localparam int R_RAD_W   = 62;
	localparam int LEN_RAD_W = 32;
	// CORDIC vector and angle widths.
	localparam int CORDIC_W  = 33;
	localparam int ANGLE_W   = 32;
	localparam int MAX_CORDIC_STAGES = 32;

	// Inverse CORDIC gain, Q0.30.
	localparam logic [29:0] CORDIC_INVK = 30'd652032875;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic [29:0] ATAN_TURNS [MAX_CORDIC_STAGES] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10680862,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,
		30'd41,        30'd20,        30'd10,        30'd5,
		30'd3,         30'd1,         30'd1,         30'd0
	};

endpackage

@@ sv/hds_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps
module hds_isqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   rad,
	output logic [W/2-1:0] root
);

	localparam int RB = W / 2;

	logic [W-1:0]  rem_s  [RB-1];
	logic [RB-1:0] root_s [RB];

	genvar k;
	for (k = 0; k < RB; k++) begin : g_step
		localparam int B = RB - 1 - k;
		logic [W-1:0]  rem_in;
		logic [RB-1:0] root_in;
		logic [W:0]    trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in  = rad;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
		assign trial = ((W+1)'(root_in) << (B + 1)) + ((W+1)'(1) << (2 * B));
		assign take  = {1'b0, rem_in} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= take ? (root_in | (RB'(1) << B)) : root_in;
			end
		end

		if (k < RB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? (rem_in - trial[W-1:0]) : rem_in;
				end
			end
		end
	end

	assign root = root_s[RB-1];

endmodule

@@ sv/hemisphere_direction_sampler.sv @@
// Top level of the hemisphere direction sampler pipeline.
// The block takes one item per clock: two uniform fractions and a surface
// normal in Q2.14, and returns one direction drawn uniformly from the
// hemisphere around that normal, saturated to 16 bits, with a flag for an
// all-zero normal (then the normal itself is returned). The pipeline is fully
// pipelined and stateless, so a new item is taken in every cycle while the
// output side takes results. The longer of the two branches sets the latency:
// either the 31-stage radius square root followed by the CORDIC rotation, or
// the 16-stage tangent length square root followed by the FRAC_BITS + 1 stage
// restoring divider. When a finished result is held by dir_stall the whole
// pipeline holds, and sample_stall is raised in that same cycle, so no item is
// lost or repeated.
`timescale 1ns / 1ps
module hemisphere_direction_sampler #(
	parameter int FRAC_BITS     = 14,
	parameter int CORDIC_STAGES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  hds_pkg::hds_in_t sample,
	output logic             dir_valid,
	input  logic             dir_stall,
	output hds_pkg::hds_out_t dir
);

	localparam int F  = FRAC_BITS;
	localparam int S  = CORDIC_STAGES;
	localparam int CW = hds_pkg::CORDIC_W;
	localparam int GW = hds_pkg::ANGLE_W;

	// Stage numbers of the two branches and of the join.
	localparam int ST_RAD   = 2;
	localparam int ST_ROOT  = ST_RAD + hds_pkg::R_RAD_W / 2;
	localparam int ST_X0    = ST_ROOT + 1;
	localparam int ST_TRIG  = ST_X0 + S + 1;
	localparam int ST_LEN   = ST_RAD + hds_pkg::LEN_RAD_W / 2;
	localparam int ST_QUO   = ST_LEN + F + 1;
	localparam int ST_A     = ST_QUO + 1;
	localparam int ST_PROD  = ST_A + 1;
	localparam int ST_B     = ST_PROD + 1;
	localparam int ST_JOIN  = (ST_TRIG > ST_B) ? ST_TRIG : ST_B;
	localparam int ST_OUT   = ST_JOIN + 2;
	localparam int D_T      = ST_JOIN - ST_TRIG;
	localparam int D_N      = ST_JOIN - ST_B;

	// Widths of the frame arithmetic.
	localparam int DVW = F + 16;           // divider remainder
	localparam int QW  = F + 1;            // quotient magnitude
	localparam int AW  = F + 2;            // signed tangent component
	localparam int NPW = AW + 16;          // tangent times normal
	localparam int DW  = AW + 17;          // cross product difference
	localparam int BW  = DW - F;           // rounded bitangent component
	localparam int LZW = 31;               // local z, Q0.30 plus sign
	localparam int PW  = CW + ((AW > BW) ? AW : BW);
	localparam int SW  = PW + 2;
	localparam int SHW = SW - 30;

	typedef struct packed {
		logic        [15:0] rand_height;
		logic        [15:0] rand_angle;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               use_x;
		logic               degen;
	} meta_t;

	typedef struct packed {
		logic signed [AW-1:0] x;
		logic signed [AW-1:0] y;
		logic signed [AW-1:0] z;
	} vec_a_t;

	typedef struct packed {
		logic signed [BW-1:0] x;
		logic signed [BW-1:0] y;
		logic signed [BW-1:0] z;
	} vec_b_t;

	typedef struct packed {
		logic signed [NPW-1:0] ay_nz;
		logic signed [NPW-1:0] az_ny;
		logic signed [NPW-1:0] az_nx;
		logic signed [NPW-1:0] ax_nz;
		logic signed [NPW-1:0] ax_ny;
		logic signed [NPW-1:0] ay_nx;
	} cross_t;

	typedef struct packed {
		logic signed [PW-1:0] xa;
		logic signed [PW-1:0] xb;
		logic signed [PW-1:0] xn;
		logic signed [PW-1:0] ya;
		logic signed [PW-1:0] yb;
		logic signed [PW-1:0] yn;
		logic signed [PW-1:0] za;
		logic signed [PW-1:0] zb;
		logic signed [PW-1:0] zn;
		logic signed [15:0]   nx;
		logic signed [15:0]   ny;
		logic signed [15:0]   nz;
		logic                 degen;
	} fin_t;

	// The whole pipeline advances together; it holds only on back-pressure.
	logic              en;
	logic [ST_OUT:1]   v_s;

	assign en           = !(v_s[ST_OUT] && dir_stall);
	assign sample_stall = !en;
	assign dir_valid    = v_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[ST_OUT-1:1], sample_valid};
		end
	end

	// Stage 1: capture the item and pick the tangent axis. The y-based
	// tangent wins a tie of magnitudes.
	logic [16:0]        mag_x;
	logic [16:0]        mag_y;
	logic               use_x;
	logic signed [15:0] p_in;
	meta_t              meta_s [1:ST_JOIN];

	assign mag_x = sample.normal_x[15] ? 17'(-17'(sample.normal_x)) : 17'(sample.normal_x);
	assign mag_y = sample.normal_y[15] ? 17'(-17'(sample.normal_y)) : 17'(sample.normal_y);
	assign use_x = mag_x > mag_y;
	assign p_in  = use_x ? sample.normal_x : sample.normal_y;

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[1].rand_height <= sample.rand_height;
			meta_s[1].rand_angle  <= sample.rand_angle;
			meta_s[1].nx          <= sample.normal_x;
			meta_s[1].ny          <= sample.normal_y;
			meta_s[1].nz          <= sample.normal_z;
			meta_s[1].use_x       <= use_x;
			meta_s[1].degen       <= (p_in == 16'sd0) && (sample.normal_z == 16'sd0);
		end
	end

	genvar k;
	for (k = 2; k <= ST_JOIN; k++) begin : g_meta
		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	// Stage 2: radicands. Local z is u1 in Q0.30, so 1 - z^2 is
	// 2^60 - u1^2 * 2^28; the tangent length squares the projection.
	logic [31:0]                  uu;
	logic signed [15:0]           p1;
	logic signed [31:0]           pp;
	logic signed [31:0]           zz;
	logic [hds_pkg::R_RAD_W-1:0]   rad_r_s2;
	logic [hds_pkg::LEN_RAD_W-1:0] rad_len_s2;

	assign uu = 32'(meta_s[1].rand_height) * 32'(meta_s[1].rand_height);
	assign p1 = meta_s[1].use_x ? meta_s[1].nx : meta_s[1].ny;
	assign pp = 32'(p1) * 32'(p1);
	assign zz = 32'(meta_s[1].nz) * 32'(meta_s[1].nz);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_r_s2   <= (hds_pkg::R_RAD_W'(1) << 60) - (hds_pkg::R_RAD_W'(uu) << 28);
			rad_len_s2 <= $unsigned(pp) + $unsigned(zz);
		end
	end

	// Radius branch: square root, gain compensation, CORDIC rotation.
	logic [hds_pkg::R_RAD_W/2-1:0] r_root;

	hds_isqrt #(
		.W(hds_pkg::R_RAD_W)
	) u_isqrt_r (
		.clk (clk),
		.en  (en),
		.rad (rad_r_s2),
		.root(r_root)
	);

	logic [61:0]          x0_prod;
	logic signed [CW-1:0] cx_s [S+1];
	logic signed [CW-1:0] cy_s [S+1];
	logic signed [GW-1:0] ca_s [S];

	assign x0_prod = 62'(r_root) * 62'(hds_pkg::CORDIC_INVK);

	// The low 30 bits of the turn are rotated; the top two pick the quadrant.
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= $signed({2'b00, x0_prod[60:30]});
			cy_s[0] <= '0;
			ca_s[0] <= $signed({2'b00, meta_s[ST_ROOT].rand_angle[13:0], 16'h0000});
		end
	end

	for (k = 0; k < S; k++) begin : g_cordic
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [GW-1:0] atan_k;
		logic                 ccw;

		assign dx     = cy_s[k] >>> k;
		assign dy     = cx_s[k] >>> k;
		assign atan_k = $signed({2'b00, hds_pkg::ATAN_TURNS[k]});
		assign ccw    = !ca_s[k][GW-1];

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s[k+1] <= ccw ? (cx_s[k] - dx) : (cx_s[k] + dx);
				cy_s[k+1] <= ccw ? (cy_s[k] + dy) : (cy_s[k] - dy);
			end
		end

		if (k < S - 1) begin : g_ang
			always_ff @(posedge clk) begin
				if (en) begin
					ca_s[k+1] <= ccw ? (ca_s[k] - atan_k) : (ca_s[k] + atan_k);
				end
			end
		end
	end

	// Quadrant fold: odd quadrants swap the axes, then signs follow.
	logic [1:0]           quad;
	logic signed [CW-1:0] c_base;
	logic signed [CW-1:0] s_base;
	logic signed [CW-1:0] lx_s;
	logic signed [CW-1:0] ly_s;

	assign quad   = meta_s[ST_X0+S].rand_angle[15:14];
	assign c_base = quad[0] ? cy_s[S] : cx_s[S];
	assign s_base = quad[0] ? cx_s[S] : cy_s[S];

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s <= (quad[1] ^ quad[0]) ? -c_base : c_base;
			ly_s <= quad[1] ? -s_base : s_base;
		end
	end

	// Frame branch: tangent length, then both tangent components by division.
	logic [hds_pkg::LEN_RAD_W/2-1:0] len_root;

	hds_isqrt #(
		.W(hds_pkg::LEN_RAD_W)
	) u_isqrt_len (
		.clk (clk),
		.en  (en),
		.rad (rad_len_s2),
		.root(len_root)
	);

	logic signed [15:0] p_len;
	logic [15:0]        mag_z_len;
	logic [15:0]        mag_p_len;
	logic [DVW-1:0]     dz_rem_s [F];
	logic [DVW-1:0]     dp_rem_s [F];
	logic [15:0]        dlen_s   [F];
	logic [QW-1:0]      dz_q_s   [F+1];
	logic [QW-1:0]      dp_q_s   [F+1];

	assign p_len     = meta_s[ST_LEN].use_x ? meta_s[ST_LEN].nx : meta_s[ST_LEN].ny;
	assign mag_z_len = meta_s[ST_LEN].nz[15] ? 16'(-meta_s[ST_LEN].nz) : meta_s[ST_LEN].nz;
	assign mag_p_len = p_len[15] ? 16'(-p_len) : p_len;

	// Each component magnitude is at most the length, so the quotient
	// fits in F + 1 bits and a restoring divider of F + 1 steps is exact.
	for (k = 0; k <= F; k++) begin : g_div
		localparam int J = F - k;
		logic [DVW-1:0] z_in;
		logic [DVW-1:0] p_in_d;
		logic [QW-1:0]  zq_in;
		logic [QW-1:0]  pq_in;
		logic [15:0]    len_in;
		logic [DVW-1:0] trial;
		logic           z_take;
		logic           p_take;

		if (k == 0) begin : g_first
			assign z_in   = DVW'(mag_z_len) << F;
			assign p_in_d = DVW'(mag_p_len) << F;
			assign zq_in  = '0;
			assign pq_in  = '0;
			assign len_in = len_root;
		end else begin : g_next
			assign z_in   = dz_rem_s[k-1];
			assign p_in_d = dp_rem_s[k-1];
			assign zq_in  = dz_q_s[k-1];
			assign pq_in  = dp_q_s[k-1];
			assign len_in = dlen_s[k-1];
		end

		assign trial  = DVW'(len_in) << J;
		assign z_take = z_in >= trial;
		assign p_take = p_in_d >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				dz_q_s[k] <= z_take ? (zq_in | (QW'(1) << J)) : zq_in;
				dp_q_s[k] <= p_take ? (pq_in | (QW'(1) << J)) : pq_in;
			end
		end

		if (k < F) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					dz_rem_s[k] <= z_take ? (z_in - trial) : z_in;
					dp_rem_s[k] <= p_take ? (p_in_d - trial) : p_in_d;
					dlen_s[k]   <= len_in;
				end
			end
		end
	end

	// Signed tangent: A = (nz, 0, -nx) / len or (0, nz, -ny) / len,
	// truncated toward zero.
	logic signed [AW-1:0] qz_mag;
	logic signed [AW-1:0] qp_mag;
	logic signed [AW-1:0] qa;
	logic signed [AW-1:0] qb;
	logic signed [15:0]   p_quo;
	vec_a_t               a_sa;

	assign qz_mag = $signed({1'b0, dz_q_s[F]});
	assign qp_mag = $signed({1'b0, dp_q_s[F]});
	assign p_quo  = meta_s[ST_QUO].use_x ? meta_s[ST_QUO].nx : meta_s[ST_QUO].ny;
	assign qa     = meta_s[ST_QUO].nz[15] ? -qz_mag : qz_mag;
	assign qb     = p_quo[15] ? qp_mag : -qp_mag;

	always_ff @(posedge clk) begin
		if (en) begin
			a_sa.x <= meta_s[ST_QUO].use_x ? qa : '0;
			a_sa.y <= meta_s[ST_QUO].use_x ? '0 : qa;
			a_sa.z <= qb;
		end
	end

	// Bitangent B = A x n: products, then rounded differences.
	cross_t cr_sp;
	vec_a_t a_sp;

	always_ff @(posedge clk) begin
		if (en) begin
			cr_sp.ay_nz <= NPW'(a_sa.y) * NPW'(meta_s[ST_A].nz);
			cr_sp.az_ny <= NPW'(a_sa.z) * NPW'(meta_s[ST_A].ny);
			cr_sp.az_nx <= NPW'(a_sa.z) * NPW'(meta_s[ST_A].nx);
			cr_sp.ax_nz <= NPW'(a_sa.x) * NPW'(meta_s[ST_A].nz);
			cr_sp.ax_ny <= NPW'(a_sa.x) * NPW'(meta_s[ST_A].ny);
			cr_sp.ay_nx <= NPW'(a_sa.y) * NPW'(meta_s[ST_A].nx);
			a_sp        <= a_sa;
		end
	end

	logic signed [DW-1:0] rnd_x;
	logic signed [DW-1:0] rnd_y;
	logic signed [DW-1:0] rnd_z;
	vec_b_t               b_sb;
	vec_a_t               a_sb;

	assign rnd_x = (DW'(cr_sp.ay_nz) - DW'(cr_sp.az_ny) + (DW'(1) << (F - 1))) >>> F;
	assign rnd_y = (DW'(cr_sp.az_nx) - DW'(cr_sp.ax_nz) + (DW'(1) << (F - 1))) >>> F;
	assign rnd_z = (DW'(cr_sp.ax_ny) - DW'(cr_sp.ay_nx) + (DW'(1) << (F - 1))) >>> F;

	always_ff @(posedge clk) begin
		if (en) begin
			b_sb.x <= rnd_x[BW-1:0];
			b_sb.y <= rnd_y[BW-1:0];
			b_sb.z <= rnd_z[BW-1:0];
			a_sb   <= a_sp;
		end
	end

	// Align the two branches at the join stage.
	logic signed [CW-1:0] lx_j;
	logic signed [CW-1:0] ly_j;
	vec_a_t               a_j;
	vec_b_t               b_j;

	if (D_T == 0) begin : g_trig_nodly
		assign lx_j = lx_s;
		assign ly_j = ly_s;
	end else begin : g_trig_dly
		logic signed [CW-1:0] lxd_s [D_T];
		logic signed [CW-1:0] lyd_s [D_T];
		always_ff @(posedge clk) begin
			if (en) begin
				lxd_s[0] <= lx_s;
				lyd_s[0] <= ly_s;
				for (int i = 1; i < D_T; i++) begin
					lxd_s[i] <= lxd_s[i-1];
					lyd_s[i] <= lyd_s[i-1];
				end
			end
		end
		assign lx_j = lxd_s[D_T-1];
		assign ly_j = lyd_s[D_T-1];
	end

	if (D_N == 0) begin : g_frame_nodly
		assign a_j = a_sb;
		assign b_j = b_sb;
	end else begin : g_frame_dly
		vec_a_t ad_s [D_N];
		vec_b_t bd_s [D_N];
		always_ff @(posedge clk) begin
			if (en) begin
				ad_s[0] <= a_sb;
				bd_s[0] <= b_sb;
				for (int i = 1; i < D_N; i++) begin
					ad_s[i] <= ad_s[i-1];
					bd_s[i] <= bd_s[i-1];
				end
			end
		end
		assign a_j = ad_s[D_N-1];
		assign b_j = bd_s[D_N-1];
	end

	// Final products of x*A + y*B + z*n.
	logic signed [LZW-1:0] lz_j;
	fin_t                  fin_sf;

	assign lz_j = $signed({1'b0, meta_s[ST_JOIN].rand_height, 14'h0000});

	always_ff @(posedge clk) begin
		if (en) begin
			fin_sf.xa    <= PW'(lx_j) * PW'(a_j.x);
			fin_sf.xb    <= PW'(ly_j) * PW'(b_j.x);
			fin_sf.xn    <= PW'(lz_j) * PW'(meta_s[ST_JOIN].nx);
			fin_sf.ya    <= PW'(lx_j) * PW'(a_j.y);
			fin_sf.yb    <= PW'(ly_j) * PW'(b_j.y);
			fin_sf.yn    <= PW'(lz_j) * PW'(meta_s[ST_JOIN].ny);
			fin_sf.za    <= PW'(lx_j) * PW'(a_j.z);
			fin_sf.zb    <= PW'(ly_j) * PW'(b_j.z);
			fin_sf.zn    <= PW'(lz_j) * PW'(meta_s[ST_JOIN].nz);
			fin_sf.nx    <= meta_s[ST_JOIN].nx;
			fin_sf.ny    <= meta_s[ST_JOIN].ny;
			fin_sf.nz    <= meta_s[ST_JOIN].nz;
			fin_sf.degen <= meta_s[ST_JOIN].degen;
		end
	end

	// Round the Q(30+F) sums to Q.F and saturate to 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [SHW-1:0] v);
		logic signed [15:0] r;
		if (v > SHW'(32767)) begin
			r = 16'sh7fff;
		end else if (v < SHW'(-32768)) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [SW-1:0] sum_z;
	hds_pkg::hds_out_t    dir_so;

	assign sum_x = (SW'(fin_sf.xa) + SW'(fin_sf.xb) + SW'(fin_sf.xn) + (SW'(1) << 29)) >>> 30;
	assign sum_y = (SW'(fin_sf.ya) + SW'(fin_sf.yb) + SW'(fin_sf.yn) + (SW'(1) << 29)) >>> 30;
	assign sum_z = (SW'(fin_sf.za) + SW'(fin_sf.zb) + SW'(fin_sf.zn) + (SW'(1) << 29)) >>> 30;

	// A degenerate normal is passed through unchanged with the flag set.
	always_ff @(posedge clk) begin
		if (en) begin
			if (fin_sf.degen) begin
				dir_so.dir_x <= fin_sf.nx;
				dir_so.dir_y <= fin_sf.ny;
				dir_so.dir_z <= fin_sf.nz;
			end else begin
				dir_so.dir_x <= sat16(sum_x[SHW-1:0]);
				dir_so.dir_y <= sat16(sum_y[SHW-1:0]);
				dir_so.dir_z <= sat16(sum_z[SHW-1:0]);
			end
			dir_so.degenerate_normal <= fin_sf.degen;
		end
	end

	assign dir = dir_so;

endmodule

@@ sv/hds_checker.sv @@
// Port-level checker of the hemisphere direction sampler, bound to the top level.
`timescale 1ns / 1ps
`include "hemisphere_direction_sampler_macros.svh"
module hds_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_stall,
	input logic              dir_valid,
	input logic              dir_stall,
	input hds_pkg::hds_out_t dir
);

	// A held result stays valid and unchanged.
	`HDS_ASSERT_NEXT(a_dir_hold, dir_valid && dir_stall, dir_valid && $stable(dir))

	// Input back-pressure only comes from a result that is being held.
	`HDS_ASSERT_IMPL(a_stall_cause, sample_stall, dir_valid && dir_stall)

	// A degenerate normal can only be the zero vector, which is passed through.
	`HDS_ASSERT_IMPL(a_degen_zero, dir_valid && dir.degenerate_normal, (dir.dir_x == 16'sd0) && (dir.dir_y == 16'sd0) && (dir.dir_z == 16'sd0))

endmodule

bind hemisphere_direction_sampler hds_checker u_hds_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_stall(sample_stall),
	.dir_valid   (dir_valid),
	.dir_stall   (dir_stall),
	.dir         (dir)
);
